/* rtl/bfsq_pkg.sv */
// Package for the bounded FIFO / sorted queue: sizes, codes and the
// logical-to-physical address helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfsq_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;

  localparam int KEY_W     = 16;
  localparam int OCC_W     = 5;
  localparam int CAP_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CMPW      = (CW > CAP_W) ? CW : CAP_W;

  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        cnt_t;
  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam logic     OP_PUSH       = 1'b0;
  localparam logic     OP_POP        = 1'b1;
  localparam cfg_idx_t REG_SORT_MODE = 1'b0;
  localparam cfg_idx_t REG_CAPACITY  = 1'b1;

  function automatic addr_t phys_addr(addr_t head, cnt_t lidx);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(lidx);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return AW'(s);
  endfunction

endpackage

`default_nettype wire

/* rtl/bfsq_if.sv */
// Channel interfaces for the queue: input item, result item, config write.
// Depends on bfsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bfsq_in_if import bfsq_pkg::*; ();
  logic valid;
  logic ready;
  logic operation;
  key_t key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface bfsq_out_if import bfsq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             accepted;
  key_t             popped_key;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, output accepted, output popped_key, output occupancy,
                  input ready);
  modport sink   (input valid, input accepted, input popped_key, input occupancy,
                  output ready);
endinterface

interface bfsq_cfg_if import bfsq_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_idx_t         index;
  logic [CAP_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/bounded_fifo_or_sorted_queue.sv */
// Bounded queue, FIFO or sorted-insert mode, held in a circular buffer RAM.
// A refused op or a FIFO push goes straight to the result; a pop reads
// the head first; a sorted push is put at the back or inserted (scan to
// the slot, shift from the back; one RAM read per cycle in both phases).
// One item in flight at a time; the result register frees input.
// Reset: synchronous rst_n clears count, head, mode (FIFO) and capacity (1).
// Depends on bfsq_pkg and bfsq_if.
`timescale 1ns / 1ps
`default_nettype none

module bounded_fifo_or_sorted_queue import bfsq_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  bfsq_in_if.sink      in_chan,
  bfsq_out_if.source   out_chan,
  bfsq_cfg_if.sink     cfg_chan
);

  typedef enum logic [2:0] {
    S_IDLE, S_POP, S_SCAN, S_SHIFT, S_INS, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic             sort_mode_r;
  logic [CAP_W-1:0] cap_r;
  key_t             key_r, key_nxt;
  addr_t            head_r, head_nxt;
  cnt_t             count_r, count_nxt;
  cnt_t             scan_idx_r, scan_idx_nxt;
  cnt_t             pos_r, pos_nxt;
  cnt_t             sh_idx_r, sh_idx_nxt;
  logic             res_acc_r, res_acc_nxt;
  key_t             res_key_r, res_key_nxt;
  cnt_t             res_occ_r, res_occ_nxt;
  logic             out_valid_r;
  logic             out_acc_r;
  key_t             out_key_r;
  logic [OCC_W-1:0] out_occ_r;

  key_t             mem [DEPTH];
  key_t             rdata_r;
  logic             mem_we;
  cnt_t             rd_l, wr_l;
  key_t             wdata;
  addr_t            raddr, waddr;

  logic [CMPW-1:0]  eff_cap;
  logic             full;
  logic             in_acc;
  logic             out_load;

  assign in_chan.ready    = (state_r == S_IDLE);
  assign in_acc           = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready   = 1'b1;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.accepted   = out_acc_r;
  assign out_chan.popped_key = out_key_r;
  assign out_chan.occupancy  = out_occ_r;

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMPW'(1);
    end else if (CMPW'(cap_r) > CMPW'(DEPTH)) begin
      eff_cap = CMPW'(DEPTH);
    end else begin
      eff_cap = CMPW'(cap_r);
    end
  end

  assign full  = (CMPW'(count_r) >= eff_cap);
  assign raddr = phys_addr(head_r, rd_l);
  assign waddr = phys_addr(head_r, wr_l);

  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    pos_nxt      = pos_r;
    sh_idx_nxt   = sh_idx_r;
    res_acc_nxt  = res_acc_r;
    res_key_nxt  = res_key_r;
    res_occ_nxt  = res_occ_r;
    mem_we       = 1'b0;
    rd_l         = '0;
    wr_l         = count_r;
    wdata        = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt     = in_chan.key;
          res_acc_nxt = 1'b0;
          res_key_nxt = '0;
          res_occ_nxt = count_r;
          if (in_chan.operation == OP_POP) begin
            if (count_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_POP;
            end
          end else if (full) begin
            state_nxt = S_DONE;
          end else if (!sort_mode_r || count_r == '0) begin
            mem_we      = 1'b1;
            wdata       = in_chan.key;
            count_nxt   = count_r + CW'(1);
            res_acc_nxt = 1'b1;
            res_occ_nxt = count_r + CW'(1);
            state_nxt   = S_DONE;
          end else begin
            scan_idx_nxt = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_POP: begin
        head_nxt    = phys_addr(head_r, CW'(1));
        count_nxt   = count_r - CW'(1);
        res_acc_nxt = 1'b1;
        res_key_nxt = rdata_r;
        res_occ_nxt = count_r - CW'(1);
        state_nxt   = S_DONE;
      end
      S_SCAN: begin
        if (rdata_r > key_r) begin
          pos_nxt    = scan_idx_r;
          rd_l       = count_r - CW'(1);
          sh_idx_nxt = count_r - CW'(1);
          state_nxt  = S_SHIFT;
        end else if (scan_idx_r == count_r - CW'(1)) begin
          mem_we      = 1'b1;
          count_nxt   = count_r + CW'(1);
          res_acc_nxt = 1'b1;
          res_occ_nxt = count_r + CW'(1);
          state_nxt   = S_DONE;
        end else begin
          rd_l         = scan_idx_r + CW'(1);
          scan_idx_nxt = scan_idx_r + CW'(1);
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        wr_l   = sh_idx_r + CW'(1);
        wdata  = rdata_r;
        if (sh_idx_r == pos_r) begin
          state_nxt = S_INS;
        end else begin
          rd_l       = sh_idx_r - CW'(1);
          sh_idx_nxt = sh_idx_r - CW'(1);
        end
      end
      S_INS: begin
        mem_we      = 1'b1;
        wr_l        = pos_r;
        count_nxt   = count_r + CW'(1);
        res_acc_nxt = 1'b1;
        res_occ_nxt = count_r + CW'(1);
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      sort_mode_r <= 1'b0;
      cap_r       <= CAP_W'(1);
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          REG_SORT_MODE: sort_mode_r <= cfg_chan.data[0];
          REG_CAPACITY:  cap_r       <= cfg_chan.data;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    scan_idx_r <= scan_idx_nxt;
    pos_r      <= pos_nxt;
    sh_idx_r   <= sh_idx_nxt;
    res_acc_r  <= res_acc_nxt;
    res_key_r  <= res_key_nxt;
    res_occ_r  <= res_occ_nxt;
    if (out_load) begin
      out_acc_r <= res_acc_r;
      out_key_r <= res_key_r;
      out_occ_r <= OCC_W'(res_occ_r);
    end
  end

endmodule

`default_nettype wire

/* verif/bounded_fifo_or_sorted_queue_tb.sv */
`timescale 1ns / 1ps
// Testbench for bounded_fifo_or_sorted_queue: directed and random push/pop items
// checked against a shadow copy of the queue, with both register settings swept.
// Depends on bfsq_pkg, bfsq_if and the RTL top level.

module bounded_fifo_or_sorted_queue_tb;
  import bfsq_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 50;
  localparam int MAX_REPORTS   = 10;
  localparam int NUM_PHASES    = 9;
  localparam int PHASE_ITEMS   = 140;

  typedef struct packed {
    logic operation;
    key_t key;
  } req_t;

  typedef struct packed {
    logic             accepted;
    key_t             popped_key;
    logic [OCC_W-1:0] occupancy;
  } reply_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bfsq_in_if  in_if();
  bfsq_out_if out_if();
  bfsq_cfg_if cfg_if();

  bounded_fifo_or_sorted_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  req_t             req_backlog[$];
  reply_t           owed_replies[$];
  key_t             shadow_keys[DEPTH];
  int unsigned      shadow_count;
  logic             shadow_sorted;
  logic [CAP_W-1:0] shadow_cap;

  int   fail_cnt     = 0;
  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  int   hold_seq     = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;
  logic in_fire      = 1'b0;

  int   phase_caps[NUM_PHASES]  = '{16, 1, 31, 2, 17, 0, 8, 16, 3};
  logic phase_modes[NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  always #5 clk = ~clk;

  function automatic reply_t queue_apply(logic op, key_t key);
    reply_t      r;
    int unsigned lim;
    int unsigned pos;
    int unsigned i;
    logic        found;
    r = '0;
    lim = (shadow_cap == 0) ? 1 : (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    if (op == OP_PUSH) begin
      if (shadow_count < lim) begin
        pos = shadow_count;
        found = 1'b0;
        if (shadow_sorted) begin
          for (i = 0; i < shadow_count; i++) begin
            if (!found && shadow_keys[i] > key) begin
              pos = i;
              found = 1'b1;
            end
          end
        end
        for (i = shadow_count; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
        end
        shadow_keys[pos] = key;
        shadow_count++;
        r.accepted = 1'b1;
      end
    end else if (shadow_count > 0) begin
      r.popped_key = shadow_keys[0];
      for (i = 1; i < shadow_count; i++) begin
        shadow_keys[i-1] = shadow_keys[i];
      end
      shadow_count--;
      r.accepted = 1'b1;
    end
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  // Sender: hold an offered item until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!(in_if.valid && !in_fire)) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_if.valid     <= 1'b1;
        in_if.operation <= req_backlog[0].operation;
        in_if.key       <= req_backlog[0].key;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      shadow_count = 0;
      shadow_sorted = 1'b0;
      shadow_cap = CAP_W'(1);
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == REG_SORT_MODE) begin
          shadow_sorted = cfg_if.data[0];
        end else if (cfg_if.index == REG_CAPACITY) begin
          shadow_cap = cfg_if.data;
        end
      end
      if (in_if.valid && in_if.ready) begin
        owed_replies.push_back(queue_apply(in_if.operation, in_if.key));
        req_backlog.delete(0);
      end
      if (out_if.valid && out_if.ready) begin
        got.accepted   = out_if.accepted;
        got.popped_key = out_if.popped_key;
        got.occupancy  = out_if.occupancy;
        if (owed_replies.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("%0t: result with none expected: acc=%0d key=%h occ=%0d",
                     $realtime, got.accepted, got.popped_key, got.occupancy);
          end
        end else begin
          want = owed_replies.pop_front();
          if (got.accepted !== want.accepted || got.popped_key !== want.popped_key ||
              got.occupancy !== want.occupancy) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS) begin
              $display("%0t: mismatch: expected acc=%0d key=%h occ=%0d, got acc=%0d key=%h occ=%0d",
                       $realtime, want.accepted, want.popped_key, want.occupancy,
                       got.accepted, got.popped_key, got.occupancy);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("** bounded_fifo_or_sorted_queue: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CAP_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic queue_req(logic op, key_t key);
    req_t r;
    r.operation = op;
    r.key = key;
    req_backlog.push_back(r);
  endtask

  task automatic drain();
    @(posedge clk);
    while (req_backlog.size() != 0 || owed_replies.size() != 0) @(posedge clk);
  endtask

  // Runs of push-heavy, balanced and pop-heavy items so the queue fills and empties.
  task automatic fill_random(int n);
    int   left;
    int   run;
    int   push_pct;
    int   style;
    req_t r;
    left = n;
    while (left > 0) begin
      run = $urandom_range(40, 6);
      if (run > left) begin
        run = left;
      end
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 15;
      endcase
      style = $urandom_range(3);
      repeat (run) begin
        r.operation = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        case (style)
          0: r.key = key_t'($urandom);
          1: r.key = key_t'($urandom_range(7));
          2: r.key = ($urandom_range(1) == 0) ? key_t'(0) : {KEY_W{1'b1}};
          default: r.key = (key_t'($urandom_range(3)) << 14) | key_t'($urandom_range(15));
        endcase
        req_backlog.push_back(r);
      end
      left -= run;
    end
  endtask

  initial begin
    int p;
    in_if.valid     = 1'b0;
    in_if.operation = OP_PUSH;
    in_if.key       = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_SORT_MODE;
    cfg_if.data     = '0;
    tx_idle_pct     = 11;
    rx_idle_pct     = 73;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: FIFO, capacity one; pop on empty, push on full.
    @(posedge clk);
    queue_req(OP_POP, 16'hFFFF);
    queue_req(OP_PUSH, 16'hFFFF);
    queue_req(OP_PUSH, 16'h0000);
    queue_req(OP_POP, 16'h5A5A);
    drain();

    // Sorted inserts, equal keys kept in arrival order.
    write_reg(REG_SORT_MODE, CAP_W'(1));
    write_reg(REG_CAPACITY, CAP_W'(16));
    @(posedge clk);
    queue_req(OP_PUSH, 16'h8000);
    queue_req(OP_PUSH, 16'h0001);
    queue_req(OP_PUSH, 16'hFFFF);
    queue_req(OP_PUSH, 16'h8000);
    queue_req(OP_PUSH, 16'h0000);
    queue_req(OP_POP, 16'h0000);
    queue_req(OP_POP, 16'h0000);
    queue_req(OP_POP, 16'h0000);
    drain();

    // Capacity zero and below the held count, back to FIFO.
    write_reg(REG_SORT_MODE, CAP_W'(0));
    write_reg(REG_CAPACITY, CAP_W'(0));
    @(posedge clk);
    queue_req(OP_PUSH, 16'h1234);
    queue_req(OP_POP, 16'h0000);
    queue_req(OP_POP, 16'h0000);
    drain();

    // Unordered entries, then sorted pushes over them.
    write_reg(REG_CAPACITY, CAP_W'(17));
    @(posedge clk);
    queue_req(OP_PUSH, 16'h0300);
    queue_req(OP_PUSH, 16'h0100);
    queue_req(OP_PUSH, 16'h0200);
    drain();
    write_reg(REG_SORT_MODE, CAP_W'(1));
    @(posedge clk);
    queue_req(OP_PUSH, 16'h0150);
    queue_req(OP_PUSH, 16'h0250);
    repeat (5) queue_req(OP_POP, 16'h0000);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_SORT_MODE, {4'($urandom_range(15)), phase_modes[p]});
      write_reg(REG_CAPACITY, CAP_W'(phase_caps[p]));
      if (p < 3) begin
        tx_idle_pct = 11;
        rx_idle_pct = 73;
      end else if (p < 6) begin
        tx_idle_pct = 73;
        rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      @(posedge clk);
      fill_random(PHASE_ITEMS);
      if (p == 0 || p == 6) begin
        hold_seq++;
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && owed_replies.size() == 0) begin
      $display("** bounded_fifo_or_sorted_queue: PASSED **");
    end else begin
      $display("** bounded_fifo_or_sorted_queue: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bfsq_pkg.sv
rtl/bfsq_if.sv
rtl/bounded_fifo_or_sorted_queue.sv
verif/bounded_fifo_or_sorted_queue_tb.sv
